FILE: rtl/sorted_priority_task_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority task queue
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_TASK_QUEUE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SPQ_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue package
// Depth, field widths, codes and the structs shared by the queue cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int Depth  = 16;
  localparam int IdW    = 8;
  localparam int PrioW  = 8;
  localparam int OccW   = 5;
  localparam int CntW   = $clog2(Depth + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Contents of one queue slot.
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   handler;
    logic [PrioW-1:0] prio;
  } slot_t;

  // What a cell shows its right-hand neighbor.
  typedef struct packed {
    slot_t slot;
    logic  gt;     // valid and priority larger than the one being inserted
  } link_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic             pop;
    logic [IdW-1:0]   handler;
    logic [PrioW-1:0] prio;
  } cmd_t;

  // Occupancy is reported modulo 32.
  function automatic logic [OccW-1:0] to_occ(input logic [CntW-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[OccW-1:0];
  endfunction

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue cell
// One slot of the sorted row: keeps, shifts back, shifts forward or loads.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spq_pkg::cmd_t  cmd_i,
  input  spq_pkg::link_t left_i,
  input  spq_pkg::slot_t right_i,
  output spq_pkg::link_t link_o
);
  import spq_pkg::*;

  logic             valid_q;
  logic [IdW-1:0]   handler_q;
  logic [PrioW-1:0] prio_q;
  slot_t            cur_slot;
  slot_t            slot_d;
  logic             gt;
  logic             take;

  assign cur_slot = '{valid: valid_q, handler: handler_q, prio: prio_q};

  assign gt = cur_slot.valid && (cur_slot.prio > cmd_i.prio);

  // Valid slots form a prefix, so the cells that change on an insert are the
  // larger entries plus the first empty one.
  assign take = gt || (!cur_slot.valid && left_i.slot.valid);

  always_comb begin
    slot_d = cur_slot;
    if (cmd_i.en) begin
      if (cmd_i.pop) begin
        slot_d = right_i;
      end else if (take) begin
        slot_d.valid = 1'b1;
        if (left_i.gt) begin
          slot_d.handler = left_i.slot.handler;
          slot_d.prio    = left_i.slot.prio;
        end else begin
          slot_d.handler = cmd_i.handler;
          slot_d.prio    = cmd_i.prio;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    handler_q <= slot_d.handler;
    prio_q    <= slot_d.prio;
  end

  assign link_o.slot = cur_slot;
  assign link_o.gt   = gt;

endmodule

FILE: rtl/sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue
// Row of cells holding handler ids sorted by ascending priority number.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (tdata / tuser, lowest bit first)
//  s_axis    in   tdata: handler[7:0], priority_req[15:8]; tuser: op[0]
//  m_axis    out  tdata: head_handler[7:0], head_priority[15:8],
//                        occupancy[20:16]; tuser: got_entry[0], status[2:1]
//
// All cells compare against the new priority and shift in the same cycle,
// so one item can be accepted each clock while the output register can
// take it. The result sits in that register; a new item is taken while
// it is empty or being taken in the same cycle.
// Reset clears the slot valid bits and the count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_priority_task_queue_defines.svh"

module sorted_priority_task_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // handler, priority_req
  input  logic [0:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // head_handler, head_priority, occupancy
  output logic [2:0]  m_axis_tuser    // got_entry, status
);
  import spq_pkg::*;

  link_t links [Depth];
  slot_t lefts_slot;
  link_t left0;
  logic [Depth-1:0] valid_vec;

  logic             accept;
  logic             is_pop;
  logic             full;
  logic             empty;
  cmd_t             cmd;
  logic [CntW-1:0]  count_q, count_d;

  logic             out_valid_q;
  logic             got_q, got_d;
  logic [IdW-1:0]   hh_q, hh_d;
  logic [PrioW-1:0] hp_q, hp_d;
  status_e          status_q, status_d;
  logic [OccW-1:0]  occ_q, occ_d;

  logic [CntW-1:0]  held_ones;
  logic             prefix_ok;
  logic             head_in_order;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_pop        = (s_axis_tuser[0] == OP_POP);
  assign full          = links[Depth-1].slot.valid;
  assign empty         = !links[0].slot.valid;

  always_comb begin
    cmd.en      = accept && (is_pop ? !empty : !full);
    cmd.pop     = is_pop;
    cmd.handler = s_axis_tdata[IdW-1:0];
    cmd.prio    = s_axis_tdata[IdW+PrioW-1:IdW];
  end

  // The head cell sees a valid, never-larger neighbor on its left.
  assign lefts_slot = '{valid: 1'b1, handler: '0, prio: '0};
  assign left0      = '{slot: lefts_slot, gt: 1'b0};

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    link_t l_in;
    slot_t r_in;
    if (i == 0) begin : g_head
      assign l_in = left0;
    end else begin : g_mid
      assign l_in = links[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign r_in = '0;
    end else begin : g_body
      assign r_in = links[i+1].slot;
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (l_in),
      .right_i(r_in),
      .link_o (links[i])
    );
    assign valid_vec[i] = links[i].slot.valid;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.en) begin
      if (cmd.pop) begin
        count_d = count_q - CntW'(1);
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_comb begin
    got_d    = 1'b0;
    hh_d     = '0;
    hp_d     = '0;
    status_d = STATUS_OK;
    if (is_pop) begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        got_d = 1'b1;
        hh_d  = links[0].slot.handler;
        hp_d  = links[0].slot.prio;
      end
    end else if (full) begin
      status_d = STATUS_FULL;
    end
    occ_d = to_occ(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      got_q    <= got_d;
      hh_q     <= hh_d;
      hp_q     <= hp_d;
      status_q <= status_d;
      occ_q    <= occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, hp_q, hh_q};
  assign m_axis_tuser  = {status_q, got_q};

  assign held_ones     = CntW'($countones(valid_vec));
  assign prefix_ok     = ((valid_vec & (valid_vec + Depth'(1))) == '0);
  assign head_in_order = !links[1].slot.valid || (links[0].slot.prio <= links[1].slot.prio);

  `SPQ_ASSERT_ALWAYS(a_count_matches, held_ones == count_q, "count and valid bits differ")
  `SPQ_ASSERT_ALWAYS(a_valid_prefix, prefix_ok, "valid slots not a prefix")
  `SPQ_ASSERT_ALWAYS(a_head_sorted, head_in_order, "head entry out of order")
  `SPQ_ASSERT_NEXT(a_pop_result, cmd.en && cmd.pop, m_axis_tvalid && m_axis_tuser[0], "pop lost its entry")

endmodule

FILE: tb/sv/sorted_priority_task_queue_monitor.sv
// ----------------------------------------------------------------------------
// Result monitor for the sorted priority task queue
// Watches both stream channels and keeps its own sorted copy of the queue.
// Each accepted input item is applied to that copy, and the outcome is
// queued. Each accepted result item is compared field by field with the
// oldest queued outcome. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // handler, priority_req
  input  logic [0:0]  s_axis_tuser,   // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // head_handler, head_priority, occupancy
  input  logic [2:0]  m_axis_tuser,   // got_entry, status
  output int          fail_count_o,
  output int          pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic             got_entry;
    logic [IdW-1:0]   handler;
    logic [PrioW-1:0] prio;
    status_e          status;
    logic [OccW-1:0]  occupancy;
  } pop_outcome_t;

  // Shadow copy of the queue: entries 0 .. held_cnt-1 are valid, 0 is the head.
  logic [IdW-1:0]   shadow_id   [Depth];
  logic [PrioW-1:0] shadow_prio [Depth];
  int               held_cnt;

  pop_outcome_t outcome_q [$];
  pop_outcome_t want;

  // Applies one item to the shadow queue and returns the result it must give.
  function automatic pop_outcome_t apply_to_queue(op_e op, logic [IdW-1:0] id,
                                                  logic [PrioW-1:0] prio);
    pop_outcome_t res;
    int           pos;
    res        = '0;
    res.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (held_cnt >= Depth) begin
        res.status = STATUS_FULL;
      end else begin
        // Equal priorities go behind the ones already held.
        pos = 0;
        while (pos < held_cnt && shadow_prio[pos] <= prio) pos++;
        for (int k = held_cnt; k > pos; k--) begin
          shadow_id[k]   = shadow_id[k-1];
          shadow_prio[k] = shadow_prio[k-1];
        end
        shadow_id[pos]   = id;
        shadow_prio[pos] = prio;
        held_cnt++;
      end
    end else if (held_cnt == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.got_entry = 1'b1;
      res.handler   = shadow_id[0];
      res.prio      = shadow_prio[0];
      for (int k = 0; k + 1 < held_cnt; k++) begin
        shadow_id[k]   = shadow_id[k+1];
        shadow_prio[k] = shadow_prio[k+1];
      end
      held_cnt--;
    end
    res.occupancy = OccW'(held_cnt);
    return res;
  endfunction

  // Four-state compare, so an unknown bit on a result counts as a mismatch.
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt  = 0;
      outcome_q.delete();
      pending_o = 0;
    end else begin
      // Results leave a register, so none can belong to an item taken now.
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result item arrived with no input item waiting for it");
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          check_field("got_entry", want.got_entry, m_axis_tuser[0]);
          check_field("status", want.status, m_axis_tuser[2:1]);
          check_field("head_handler", want.handler, m_axis_tdata[7:0]);
          check_field("head_priority", want.prio, m_axis_tdata[15:8]);
          check_field("occupancy", want.occupancy, m_axis_tdata[20:16]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_q.push_back(apply_to_queue(op_e'(s_axis_tuser[0]), s_axis_tdata[7:0],
                                           s_axis_tdata[15:8]));
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// Testbench for the sorted priority task queue
// Drives insert and pop items with random gaps against a randomly stalling
// result channel. A directed opening covers the empty pop, equal priorities,
// extreme ids and priorities, and the full queue; random phases then lean
// toward filling, draining or churning the queue. The monitor predicts and
// checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_priority_task_queue;
  import spq_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 20;
  localparam int RandomItems   = 1850;
  localparam int PhaseLen      = 100;

  typedef enum int {
    PRIO_ANY,
    PRIO_CLUSTER,
    PRIO_EXTREME
  } prio_spread_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int fail_count;
  int pending;
  bit calm = 1'b0;  // no gaps and no stalls while set
  int idle_cycles = 0;
  int ready_stall = 0;
  int sent;

  always #10 clk_i = ~clk_i;

  sorted_priority_task_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sorted_priority_task_queue_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (calm) begin
      m_axis_tready = 1'b1;
    end else if (ready_stall > 0) begin
      m_axis_tready = 1'b0;
      ready_stall--;
    end else begin
      m_axis_tready = 1'b1;
      ready_stall   = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance of the item.
  task automatic send_item(op_e op, logic [IdW-1:0] id, logic [PrioW-1:0] prio);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {prio, id};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    int           ins_pct;
    int           ph;
    prio_spread_e spread;
    op_e          op;
    logic [7:0]   prio;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed opening: empty pop, ties, extremes, then a full queue.
    send_item(OP_POP, 8'hFF, 8'hFF);
    send_item(OP_INSERT, 8'h00, 8'h80);
    send_item(OP_INSERT, 8'hFF, 8'h80);
    send_item(OP_INSERT, 8'h11, 8'hFF);
    send_item(OP_INSERT, 8'h22, 8'h00);
    send_item(OP_INSERT, 8'h33, 8'h00);
    send_item(OP_INSERT, 8'h44, 8'h7F);
    for (int i = 0; i < 10; i++) begin
      send_item(OP_INSERT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    send_item(OP_INSERT, 8'hA5, 8'h00);
    repeat (4) send_item(OP_POP, 8'h00, 8'h00);

    sent = 0;
    ph   = 0;
    while (sent < RandomItems) begin
      case (ph % 4)
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        2:       ins_pct = 50;
        default: ins_pct = 60;
      endcase
      spread = prio_spread_e'($urandom_range(0, 2));
      calm   = (ph % 5 == 2);
      for (int n = 0; n < PhaseLen; n++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
        case (spread)
          PRIO_ANY:     prio = 8'($urandom_range(0, 255));
          PRIO_CLUSTER: prio = 8'($urandom_range(0, 3));
          default:      prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
        send_item(op, 8'($urandom_range(0, 255)), prio);
      end
      if (ph % 3 == 0) wait_for_results();
      ph++;
    end
    calm = 1'b0;

    wait_for_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
